>>> hw/rtl/crls_pkg.sv
package crls_pkg;

  // sample and result field widths
  localparam int unsigned SAMPLE_BITS      = 16;
  localparam int unsigned MAX_SAMPLES_DEF  = 1024;
  localparam int unsigned REC_BITS         = 21;
  localparam int unsigned LPTS_BITS        = 21;
  localparam int unsigned LCNT_BITS        = 20;
  localparam int unsigned LEN_BITS         = 11;

  // configuration port
  localparam int unsigned CFG_IDX_BITS     = 2;
  localparam int unsigned CFG_DATA_BITS    = 16;
  localparam int unsigned THRESH_BITS      = 16;
  localparam int unsigned MINL_BITS        = 11;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LINE  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SELF_MODE = 2'd2;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = '0;
  localparam logic [MINL_BITS-1:0]   MINL_RESET   = 11'd2;

  // input word
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic                          last_sample;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [REC_BITS-1:0]  recurrent_points;
    logic [LPTS_BITS-1:0] line_points;
    logic [LCNT_BITS-1:0] line_total;
    logic [LEN_BITS-1:0]  longest_line;
    logic [LEN_BITS-1:0]  window_length;
    logic                 truncated;
  } out_word_t;

  // controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WALK,
    ST_DRAIN
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic store;
    logic start;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_end;
    logic pipe_busy;
    logic out_full;
  } dp_status_t;

endpackage

>>> hw/rtl/cross_recurrence_line_stats.sv
// the result follows the closing word after the walk over all n*n matrix points (n = pairs in the window) and the drain
// the walk reads one matrix point at a time: one read a cycle from each sample memory
// words are taken one per cycle while loading; none are taken during the walk and drain
// a finished walk waits while the previous result is still held in the output register
// reset: asynchronous active low, empties the window and loads the register defaults
module cross_recurrence_line_stats import crls_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_word_t                 in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_word_t                out_word_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencing
  crls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.last_sample),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // sample store, recurrence test and statistics
  crls_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> hw/rtl/crls_ctrl.sv
module crls_ctrl import crls_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    accept     = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        // words are taken every cycle while loading
        in_stall_o  = 1'b0;
        accept      = in_valid_i;
        cmd_o.store = accept;
        if (accept && in_last_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (status_i.walk_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // hand over once the pipe is empty and the output register is free
        if (!status_i.pipe_busy && !status_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

>>> hw/rtl/crls_datapath.sv
module crls_datapath import crls_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  in_word_t                 in_word_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  ctrl_cmd_t                cmd_i,
  output dp_status_t               status_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_word_t                out_word_o
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned LW = (CW > MINL_BITS) ? CW : MINL_BITS;
  localparam int unsigned DW = SAMPLE_BITS + 1;

  // configuration registers
  logic [THRESH_BITS-1:0] thresh_q;
  logic [MINL_BITS-1:0]   minl_q;
  logic                   self_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
      minl_q   <= MINL_RESET;
      self_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thresh_q <= cfg_data_i[THRESH_BITS-1:0];
        CFG_MIN_LINE:  minl_q   <= cfg_data_i[MINL_BITS-1:0];
        CFG_SELF_MODE: self_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // fill count and overflow flag
  logic [CW-1:0] cnt_q;
  logic          ovf_q;
  logic          store_full;
  logic [CW-1:0] n_q;
  logic [AW-1:0] last_idx_q;
  logic          trunc_q;

  assign store_full = (cnt_q == CW'(MAX_SAMPLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      n_q        <= '0;
      last_idx_q <= '0;
      trunc_q    <= 1'b0;
    end else if (cmd_i.start) begin
      n_q        <= store_full ? cnt_q : cnt_q + CW'(1);
      last_idx_q <= store_full ? AW'(MAX_SAMPLES - 1) : cnt_q[AW-1:0];
      trunc_q    <= ovf_q || store_full;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.store) begin
      if (store_full) begin
        ovf_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // diagonal walk address counters
  logic          up_q;
  logic [AW-1:0] d_q, ia_q, jb_q;
  logic          diag_end, last_diag, walk_end, lines_en;

  assign diag_end  = up_q ? (jb_q == last_idx_q) : (ia_q == last_idx_q);
  assign last_diag = (d_q == last_idx_q);
  assign walk_end  = diag_end && last_diag && (!up_q || (last_idx_q == '0));
  assign lines_en  = !self_q || (up_q && (d_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q <= 1'b1;
      d_q  <= '0;
      ia_q <= '0;
      jb_q <= '0;
    end else if (cmd_i.start) begin
      up_q <= 1'b1;
      d_q  <= '0;
      ia_q <= '0;
      jb_q <= '0;
    end else if (cmd_i.step) begin
      if (!diag_end) begin
        ia_q <= ia_q + AW'(1);
        jb_q <= jb_q + AW'(1);
      end else if (up_q && last_diag) begin
        // upper half done, go below the main diagonal
        up_q <= 1'b0;
        d_q  <= AW'(1);
        ia_q <= AW'(1);
        jb_q <= '0;
      end else begin
        d_q  <= d_q + AW'(1);
        ia_q <= up_q ? '0 : d_q + AW'(1);
        jb_q <= up_q ? d_q + AW'(1) : '0;
      end
    end
  end

  // sample memories, registered read
  logic signed [SAMPLE_BITS-1:0] mem_a [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] mem_b [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !store_full) begin
      mem_a[cnt_q[AW-1:0]] <= in_word_i.sample_a;
      mem_b[cnt_q[AW-1:0]] <= in_word_i.sample_b;
    end
    if (cmd_i.step) begin
      rd_a_q <= mem_a[ia_q];
      rd_b_q <= mem_b[jb_q];
    end
  end

  // stage one tags
  logic s1_valid_q, s1_end_q, s1_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_end_q   <= 1'b0;
      s1_len_q   <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.step;
      s1_end_q   <= diag_end;
      s1_len_q   <= lines_en;
    end
  end

  // recurrence test
  logic signed [DW-1:0] diff;
  logic        [DW-1:0] mag;
  logic                 rec;

  assign diff = DW'(rd_a_q) - DW'(rd_b_q);
  assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign rec  = (mag <= DW'(thresh_q));

  logic s2_valid_q, s2_end_q, s2_len_q, s2_rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_end_q   <= 1'b0;
      s2_len_q   <= 1'b0;
      s2_rec_q   <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
      s2_end_q   <= s1_end_q;
      s2_len_q   <= s1_len_q;
      s2_rec_q   <= rec;
    end
  end

  // run tracking and line statistics
  logic [CW-1:0]        run_q, run_d, run_inc, close_val;
  logic                 closing, counted;
  logic [REC_BITS-1:0]  rec_cnt_q;
  logic [LPTS_BITS-1:0] lpts_q;
  logic [LCNT_BITS-1:0] lcnt_q;
  logic [CW-1:0]        longest_q;

  assign run_inc   = run_q + CW'(1);
  assign close_val = s2_rec_q ? run_inc : run_q;
  assign closing   = !s2_rec_q || s2_end_q;
  assign run_d     = (s2_rec_q && !s2_end_q) ? run_inc : '0;
  assign counted   = closing && s2_len_q && (close_val != '0) &&
                     (LW'(close_val) >= LW'(minl_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= '0;
      rec_cnt_q <= '0;
      lpts_q    <= '0;
      lcnt_q    <= '0;
      longest_q <= '0;
    end else if (cmd_i.start) begin
      run_q     <= '0;
      rec_cnt_q <= '0;
      lpts_q    <= '0;
      lcnt_q    <= '0;
      longest_q <= '0;
    end else if (s2_valid_q) begin
      run_q <= run_d;
      if (s2_rec_q) begin
        rec_cnt_q <= rec_cnt_q + REC_BITS'(1);
      end
      if (counted) begin
        lpts_q <= lpts_q + LPTS_BITS'(close_val);
        lcnt_q <= lcnt_q + LCNT_BITS'(1);
        if (close_val > longest_q) begin
          longest_q <= close_val;
        end
      end
    end
  end

  // statistics of the finished window
  out_word_t stats_word;

  assign stats_word.recurrent_points = rec_cnt_q;
  assign stats_word.line_points      = lpts_q;
  assign stats_word.line_total       = lcnt_q;
  assign stats_word.longest_line     = LEN_BITS'(longest_q);
  assign stats_word.window_length    = LEN_BITS'(n_q);
  assign stats_word.truncated        = trunc_q;

  // result word register, frees the statistics for the next window
  logic      out_valid_q;
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
      out_q       <= stats_word;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign status_o.walk_end  = walk_end;
  assign status_o.pipe_busy = s1_valid_q || s2_valid_q;
  assign status_o.out_full  = out_valid_q;

endmodule

>>> bench/cross_recurrence_line_stats_tb.sv
`timescale 1ns / 1ps

module cross_recurrence_line_stats_tb;
  import crls_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 480;
  // the widest window of the run walks 90 x 90 points with nothing moving on either side
  localparam int unsigned WATCHDOG_LIMIT = 50_000;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  typedef enum int {
    WIN_NOISE,
    WIN_CROSS,
    WIN_SELF,
    WIN_RAILS
  } window_style_e;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  in_word_t                 in_word_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  out_word_t                out_word_o;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i  = '0;

  cross_recurrence_line_stats DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // sample words waiting for the driver, window statistics waiting for the block
  in_word_t  pending_words[$];
  out_word_t stats_due[$];
  out_word_t want_stats;

  // mirror of the registers
  int thresh_mirror  = 0;
  int min_len_mirror = 2;
  bit self_mirror    = 1'b0;

  // mirror of the sample stores
  logic signed [SAMPLE_BITS-1:0] series_a_seen [MAX_SAMPLES_DEF];
  logic signed [SAMPLE_BITS-1:0] series_b_seen [MAX_SAMPLES_DEF];
  int fill_count   = 0;
  bit dropped_flag = 1'b0;

  // line accumulators of the window being evaluated
  int line_pts_acc;
  int line_cnt_acc;
  int line_max_acc;

  // idling control
  bit calm       = 1'b0;
  int idle_odds  = 0;
  int send_gap   = 0;
  int stall_left = 0;

  int mismatch_count = 0;
  int result_index   = 0;
  int quiet_cycles   = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // recurrence test of one matrix point
  function automatic bit recurrent(int i, int j);
    int diff;
    diff = int'(series_a_seen[i]) - int'(series_b_seen[j]);
    if (diff < 0) diff = -diff;
    return diff <= thresh_mirror;
  endfunction

  // a maximal run ends: count it if long enough
  function automatic void close_run(int run);
    int shortest;
    shortest = (min_len_mirror == 0) ? 1 : min_len_mirror;
    if (run > 0 && run >= shortest) begin
      line_pts_acc += run;
      line_cnt_acc++;
      if (run > line_max_acc) line_max_acc = run;
    end
  endfunction

  function automatic void walk_diagonal(int r, int c, int len);
    int run;
    run = 0;
    for (int k = 0; k < len; k++) begin
      if (recurrent(r + k, c + k)) begin
        run++;
      end else begin
        close_run(run);
        run = 0;
      end
    end
    close_run(run);
  endfunction

  // statistics of the stored window
  function automatic out_word_t window_stats();
    out_word_t res;
    int n;
    int hits;
    n = fill_count;
    hits = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (recurrent(i, j)) hits++;
    line_pts_acc = 0;
    line_cnt_acc = 0;
    line_max_acc = 0;
    for (int d = self_mirror ? 1 : 0; d < n; d++) begin
      walk_diagonal(0, d, n - d);
      if (!self_mirror && d > 0) walk_diagonal(d, 0, n - d);
    end
    res.recurrent_points = REC_BITS'(hits);
    res.line_points      = LPTS_BITS'(line_pts_acc);
    res.line_total       = LCNT_BITS'(line_cnt_acc);
    res.longest_line     = LEN_BITS'(line_max_acc);
    res.window_length    = LEN_BITS'(n);
    res.truncated        = dropped_flag;
    return res;
  endfunction

  // one accepted word: store or drop it, close the window on the last one
  function automatic void absorb_pair(in_word_t w);
    if (fill_count < MAX_SAMPLES_DEF) begin
      series_a_seen[fill_count] = w.sample_a;
      series_b_seen[fill_count] = w.sample_b;
      fill_count++;
    end else begin
      dropped_flag = 1'b1;
    end
    if (w.last_sample) begin
      stats_due.insert(stats_due.size(), window_stats());
      fill_count   = 0;
      dropped_flag = 1'b0;
    end
  endfunction

  function automatic void push_pair(int a, int b, bit last);
    in_word_t w;
    w.sample_a    = a[SAMPLE_BITS-1:0];
    w.sample_b    = b[SAMPLE_BITS-1:0];
    w.last_sample = last;
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic int rail_value();
    case ($urandom_range(0, 3))
      0:       return 32767;
      1:       return -32768;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // one window of n pairs with the given kind of content
  task automatic queue_window(int n, window_style_e style);
    int trace [0:MAX_SAMPLES_DEF+15];
    int shift;
    int walk_step;
    int v;
    shift     = $urandom_range(0, 3);
    walk_step = $urandom_range(0, 3);
    v         = int'($signed(SAMPLE_BITS'($urandom)));
    // slowly wandering series, sometimes flat
    for (int k = 0; k < n + 4 && k <= MAX_SAMPLES_DEF + 15; k++) begin
      trace[k] = v;
      v += int'($urandom_range(0, 2 * walk_step)) - walk_step;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end
    for (int k = 0; k < n; k++) begin
      case (style)
        WIN_NOISE: push_pair($urandom, $urandom, k == n - 1);
        WIN_RAILS: push_pair(rail_value(), rail_value(), k == n - 1);
        WIN_SELF:  push_pair(trace[k], trace[k], k == n - 1);
        default:   push_pair(trace[k], trace[k + shift] + $urandom_range(0, 1), k == n - 1);
      endcase
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_THRESHOLD: thresh_mirror  = int'(data[THRESH_BITS-1:0]);
      CFG_MIN_LINE:  min_len_mirror = int'(data[MINL_BITS-1:0]);
      CFG_SELF_MODE: self_mirror    = data[0];
      default: ;
    endcase
  endtask

  // every word sent, every result back, block given time to settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || stats_due.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_threshold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CFG_DATA_BITS'($urandom_range(0, 8));
    if (r < 65) return CFG_DATA_BITS'($urandom_range(0, 400));
    if (r < 75) return '0;
    if (r < 85) return '1;
    return CFG_DATA_BITS'($urandom);
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_min_len();
    logic [CFG_DATA_BITS-1:0] data;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)      data = CFG_DATA_BITS'($urandom_range(1, 3));
    else if (r < 45) data = '0;
    else if (r < 75) data = CFG_DATA_BITS'($urandom_range(2, 8));
    else if (r < 85) data = CFG_DATA_BITS'(1024);
    else             data = CFG_DATA_BITS'($urandom_range(0, 2047));
    // junk above the register width
    if ($urandom_range(0, 3) == 0)
      data[CFG_DATA_BITS-1:MINL_BITS] = (CFG_DATA_BITS - MINL_BITS)'($urandom);
    return data;
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 12);
    if (r < 97) return $urandom_range(13, 40);
    return $urandom_range(41, 90);
  endfunction

  function automatic window_style_e pick_style();
    int r;
    r = $urandom_range(0, 99);
    if (self_mirror && r < 60) return WIN_SELF;
    if (r < 45) return WIN_CROSS;
    if (r < 65) return WIN_SELF;
    if (r < 85) return WIN_NOISE;
    return WIN_RAILS;
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_word_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          send_gap = $urandom_range(1, 8);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      stall_left = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d %s: expected %0d, got %0d", result_index, field, want, got);
    end
  endtask

  // predict on accepted words, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) absorb_pair(in_word_i);
      if (out_valid_o && !out_stall_i) begin
        if (stats_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d arrived with nothing expected: %p", result_index, out_word_o);
        end else begin
          want_stats = stats_due.pop_front();
          check_field("recurrent_points", out_word_o.recurrent_points,
                      want_stats.recurrent_points);
          check_field("line_points", out_word_o.line_points, want_stats.line_points);
          check_field("line_total", out_word_o.line_total, want_stats.line_total);
          check_field("longest_line", out_word_o.longest_line, want_stats.longest_line);
          check_field("window_length", out_word_o.window_length, want_stats.window_length);
          check_field("truncated", out_word_o.truncated, want_stats.truncated);
        end
        result_index++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int random_items;
    int windows;
    int n;
    random_items = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    idle_odds = 5;

    // rail samples with a matching tail, reset settings
    push_pair(32767, -32768, 0);
    push_pair(-32768, 32767, 0);
    push_pair(0, 0, 0);
    push_pair(0, 0, 1);
    // window of a single pair
    push_pair(-1, -1, 1);
    wait_drained();

    // widest threshold, zero minimum length, self mode, junk in upper data bits
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    write_reg(CFG_MIN_LINE, 16'hF800);
    write_reg(CFG_SELF_MODE, 16'hFFFF);
    write_reg(CFG_SPARE, 16'h1234);
    @(negedge clk_i);
    push_pair(32767, 32767, 0);
    push_pair(-32768, -32768, 0);
    push_pair(32767, -32768, 0);
    push_pair(-32768, 32767, 1);
    wait_drained();

    // tight threshold, minimum length beyond the window, cross mode
    write_reg(CFG_THRESHOLD, 16'h0001);
    write_reg(CFG_MIN_LINE, 16'h0400);
    write_reg(CFG_SELF_MODE, 16'h0002);
    @(negedge clk_i);
    push_pair(100, 101, 0);
    push_pair(-5, 100, 0);
    push_pair(101, -4, 1);
    wait_drained();

    // periodic series against itself, every run off the main diagonal is a line
    write_reg(CFG_THRESHOLD, 16'd2);
    write_reg(CFG_MIN_LINE, 16'd1);
    write_reg(CFG_SELF_MODE, 16'd1);
    @(negedge clk_i);
    for (int k = 0; k < 6; k++) push_pair((k % 3) * 10, (k % 3) * 10, k == 5);
    wait_drained();

    // ramp against its shifted copy, cross mode
    write_reg(CFG_THRESHOLD, 16'd0);
    write_reg(CFG_MIN_LINE, 16'd3);
    write_reg(CFG_SELF_MODE, 16'd0);
    @(negedge clk_i);
    for (int k = 0; k < 5; k++) push_pair(k * 7, (k + 1) * 7, k == 4);
    wait_drained();

    // random groups of windows, new settings and idling between groups
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) write_reg(CFG_THRESHOLD, pick_threshold());
      if ($urandom_range(0, 2) != 0) write_reg(CFG_MIN_LINE, pick_min_len());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SELF_MODE, CFG_DATA_BITS'($urandom));
      if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
      @(negedge clk_i);
      case ($urandom_range(0, 2))
        0:       idle_odds = 0;
        1:       idle_odds = 4;
        default: idle_odds = 12;
      endcase
      windows = $urandom_range(3, 12);
      for (int w = 0; w < windows; w++) begin
        n = pick_size();
        queue_window(n, pick_style());
        random_items += n;
      end
      wait_drained();
    end

    // steady tail: every point recurrent, no run reaches the minimum length
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    write_reg(CFG_MIN_LINE, 16'd1024);
    write_reg(CFG_SELF_MODE, 16'd0);
    @(negedge clk_i);
    calm = 1'b1;
    queue_window($urandom_range(2, 10), WIN_CROSS);
    queue_window($urandom_range(2, 10), WIN_RAILS);
    queue_window($urandom_range(60, 90), WIN_NOISE);
    wait_drained();
    repeat (64) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/crls_pkg.sv
hw/rtl/crls_ctrl.sv
hw/rtl/crls_datapath.sv
hw/rtl/cross_recurrence_line_stats.sv
bench/cross_recurrence_line_stats_tb.sv
